// ===== hdl/mgv_pkg.sv =====
// ----------------------------------------------------------------------------
// mgv_pkg: shared types and helpers for the masked gate verifier
// Transaction payload structs, per-slot storage word and the carry-mask
// prefix-XOR function.
// ----------------------------------------------------------------------------
package mgv_pkg;

  localparam int WordBits   = 32;
  localparam int GateBits   = 16;
  localparam int CfgBits    = 2;
  localparam int PartiesDef = 3;

  typedef logic [WordBits-1:0] word_t;

  // Input transaction: one revealed party slot
  typedef struct packed {
    logic  func;
    word_t x_pub;
    word_t y_pub;
    word_t x_mask;
    word_t y_mask;
    word_t mask_rand;
    word_t prod_rand;
    word_t hidden_msg;
    word_t correction;
    logic  last_slot;
  } item_t;

  // Output transaction: one result per stored slot
  typedef struct packed {
    word_t               slot_broadcast;
    word_t               out_mask;
    word_t               out_pub;
    logic [GateBits-1:0] gate_index;
    logic                slot_index;
    logic                last_result;
  } result_t;

  // Words kept per slot
  typedef struct packed {
    word_t x_mask;
    word_t y_mask;
    word_t lambda;
    word_t product;
  } slot_word_t;

  // Carry masks: bit i is the XOR of bits 0..i-1 of w
  function automatic word_t carry_mask(word_t w);
    word_t v;
    v = w;
    for (int k = 1; k < WordBits; k = k * 2) begin
      v = v ^ (v << k);
    end
    return v << 1;
  endfunction

endpackage

// ===== hdl/masked_gate_verify_unit.sv =====
// ----------------------------------------------------------------------------
// masked_gate_verify_unit: verifier for one masked 32-bit AND / ADD gate
// Stores the revealed slots of a gate, rebuilds the public carry word
// bit-serially for ADD, then emits one result per stored slot.
// ----------------------------------------------------------------------------
// Usage and timing: send one transaction per revealed slot, last_slot set on
// the final one; at most PARTIES-1 slots are stored per gate, extra slot data
// is dropped. Non-last transactions are taken without stall. The last one
// closes the gate: for ADD a bit-serial carry engine walks all 32 bits of the
// public words one bit per cycle, then the slot memory is read back one slot
// at a time through its single registered read port (read state S_RD, then
// emit state S_EMIT, which waits while the output is stalled). item_stall is
// high from the last transaction until the final result has been loaded into
// the output register; that register then waits for the consumer while the
// next gate already loads. hidden_party may only be written while idle.
// ----------------------------------------------------------------------------
module masked_gate_verify_unit #(
  parameter int PARTIES = mgv_pkg::PartiesDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mgv_pkg::CfgBits-1:0] cfg_wr_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  mgv_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output mgv_pkg::result_t            result
);

  localparam int NSlots  = PARTIES - 1;
  localparam int CntW    = $clog2(PARTIES);
  localparam int IdxW    = (NSlots > 1) ? $clog2(NSlots) : 1;
  localparam int BitCntW = $clog2(mgv_pkg::WordBits);

  localparam logic [CntW-1:0]    SlotMax = CntW'(NSlots);
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(mgv_pkg::WordBits - 1);

  // FSM codes
  localparam logic [1:0] S_LOAD  = 2'd0;  // taking slot transactions
  localparam logic [1:0] S_CARRY = 2'd1;  // serial carry rebuild (ADD)
  localparam logic [1:0] S_RD    = 2'd2;  // slot memory read issued
  localparam logic [1:0] S_EMIT  = 2'd3;  // result formed, waiting for output register

  logic [1:0] state;

  // Configuration
  logic [mgv_pkg::CfgBits-1:0] hidden_party;
  logic                        p0_rev;

  // Gate bookkeeping
  logic [CntW-1:0]              slot_count;
  logic [CntW-1:0]              emit_idx;
  logic [mgv_pkg::GateBits-1:0] gate_counter;

  // Per-gate public words, captured from the last transaction.
  // They rotate through the carry engine and are back in place when it ends.
  mgv_pkg::word_t xh, yh, hmsg, corr;
  logic           func_q;

  // XOR of all stored slot words, loaded by the first slot of a gate
  mgv_pkg::word_t acc_x, acc_y, acc_p, acc_l;

  // Carry engine
  logic [BitCntW-1:0] bit_cnt;
  logic               c_bit;   // public carry at the current bit
  logic               cm_bit;  // running prefix XOR of summed lambda
  mgv_pkg::word_t     chat;    // rebuilt carry word, filled from the top

  // Slot memory
  mgv_pkg::slot_word_t slot_mem [NSlots];
  mgv_pkg::slot_word_t rd_word;

  logic item_acc;
  logic store_slot;
  logic first_slot;
  logic out_load;
  logic last_res;

  assign p0_rev     = (hidden_party != '0);
  assign item_stall = (state != S_LOAD);
  assign item_acc   = item_valid && !item_stall;
  assign store_slot = item_acc && (slot_count < SlotMax);
  assign first_slot = (slot_count == '0);
  assign out_load   = (state == S_EMIT) && (!result_valid || !result_stall);
  assign last_res   = ((emit_idx + CntW'(1)) == slot_count);

  // ---- serial carry step: one bit of every word per cycle ----
  logic pb, qb, sxb, syb, sr, rb;

  always_comb begin
    pb  = xh[0] ^ c_bit;
    qb  = yh[0] ^ c_bit;
    sxb = acc_x[0] ^ cm_bit;
    syb = acc_y[0] ^ cm_bit;
    sr  = (pb & syb) ^ (qb & sxb) ^ acc_p[0] ^ acc_l[0]
        ^ (p0_rev & ((pb & qb) ^ corr[0]));
    rb  = hmsg[0] ^ sr;
  end

  // ---- per-slot result from the registered memory word ----
  mgv_pkg::word_t cm, ph, qh, s_word, om_word, pub_word, fix_word;

  always_comb begin
    cm       = func_q ? mgv_pkg::carry_mask(rd_word.lambda) : '0;
    ph       = xh ^ (func_q ? chat : '0);
    qh       = yh ^ (func_q ? chat : '0);
    // party 0 term only on slot 0 when party 0 is revealed
    fix_word = ((emit_idx == '0) && p0_rev) ? ((ph & qh) ^ corr) : '0;
    s_word   = (ph & (rd_word.y_mask ^ cm)) ^ (qh & (rd_word.x_mask ^ cm))
             ^ rd_word.product ^ rd_word.lambda ^ fix_word;
    om_word  = func_q ? (rd_word.x_mask ^ rd_word.y_mask ^ cm) : rd_word.lambda;
    // AND output is hidden_msg XOR all slot broadcasts, folded over the sums
    pub_word = func_q ? (xh ^ yh ^ chat)
             : (hmsg ^ (xh & acc_y) ^ (yh & acc_x) ^ acc_p ^ acc_l
                ^ (p0_rev ? ((xh & yh) ^ corr) : '0));
  end

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      hidden_party <= '0;
      slot_count   <= '0;
      gate_counter <= '0;
      emit_idx     <= '0;
      bit_cnt      <= '0;
    end else begin
      if (cfg_wr_en) begin
        hidden_party <= cfg_wr_data;
      end
      unique case (state)
        S_LOAD: begin
          if (store_slot) begin
            slot_count <= slot_count + CntW'(1);
          end
          if (item_acc && item.last_slot) begin
            emit_idx <= '0;
            bit_cnt  <= '0;
            state    <= item.func ? S_CARRY : S_RD;
          end
        end
        S_CARRY: begin
          bit_cnt <= bit_cnt + BitCntW'(1);
          if (bit_cnt == LastBit) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            if (last_res) begin
              slot_count   <= '0;
              gate_counter <= gate_counter + mgv_pkg::GateBits'(1);
              state        <= S_LOAD;
            end else begin
              emit_idx <= emit_idx + CntW'(1);
              state    <= S_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (store_slot) begin
      acc_x <= item.x_mask    ^ (first_slot ? '0 : acc_x);
      acc_y <= item.y_mask    ^ (first_slot ? '0 : acc_y);
      acc_p <= item.prod_rand ^ (first_slot ? '0 : acc_p);
      acc_l <= item.mask_rand ^ (first_slot ? '0 : acc_l);
    end else if (state == S_CARRY) begin
      acc_x <= {acc_x[0], acc_x[mgv_pkg::WordBits-1:1]};
      acc_y <= {acc_y[0], acc_y[mgv_pkg::WordBits-1:1]};
      acc_p <= {acc_p[0], acc_p[mgv_pkg::WordBits-1:1]};
      acc_l <= {acc_l[0], acc_l[mgv_pkg::WordBits-1:1]};
    end

    if (item_acc && item.last_slot) begin
      func_q <= item.func;
      xh     <= item.x_pub;
      yh     <= item.y_pub;
      hmsg   <= item.hidden_msg;
      corr   <= item.correction;
      c_bit  <= 1'b0;
      cm_bit <= 1'b0;
    end else if (state == S_CARRY) begin
      xh     <= {xh[0], xh[mgv_pkg::WordBits-1:1]};
      yh     <= {yh[0], yh[mgv_pkg::WordBits-1:1]};
      hmsg   <= {hmsg[0], hmsg[mgv_pkg::WordBits-1:1]};
      corr   <= {corr[0], corr[mgv_pkg::WordBits-1:1]};
      // chat bit b lands at position b once the walk is done; bit 0 stays zero
      chat   <= {c_bit, chat[mgv_pkg::WordBits-1:1]};
      c_bit  <= c_bit ^ rb;
      cm_bit <= cm_bit ^ acc_l[0];
    end
  end

  // ---- slot memory: one write port, one registered read port ----
  always_ff @(posedge clk) begin
    if (store_slot) begin
      slot_mem[slot_count[IdxW-1:0]] <= '{x_mask:  item.x_mask,
                                          y_mask:  item.y_mask,
                                          lambda:  item.mask_rand,
                                          product: item.prod_rand};
    end
    rd_word <= slot_mem[emit_idx[IdxW-1:0]];
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.slot_broadcast <= s_word;
      result.out_mask       <= om_word;
      result.out_pub        <= pub_word;
      result.gate_index     <= gate_counter;
      result.slot_index     <= emit_idx[0];
      result.last_result    <= last_res;
    end
  end

  // ---- assertions ----
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= SlotMax)
    else $error("slot count above slot capacity");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_EMIT) |-> (emit_idx < slot_count))
    else $error("emission index past stored slots");

  a_add_enters_carry: assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.last_slot && item.func) |=> (state == S_CARRY))
    else $error("ADD gate skipped carry rebuild");

  a_gate_advance: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_res) |=>
      (gate_counter == mgv_pkg::GateBits'($past(gate_counter) + 1'b1))
      && (slot_count == '0))
    else $error("gate end did not advance gate counter");

  a_stall_in_gate: assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.last_slot) |=> item_stall)
    else $error("new transaction taken while gate still in work");

endmodule

// ===== bench/masked_gate_verify_unit_test.sv =====
// ----------------------------------------------------------------------------
// masked_gate_verify_unit_test: self-checking bench for the masked gate verifier
// Feeds gates of revealed-slot transactions (AND and ADD, short and overlong),
// predicts every per-slot result in a scoreboard and compares field by field,
// with random idle on both handshakes and several hidden_party settings.
// ----------------------------------------------------------------------------
module masked_gate_verify_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots     = mgv_pkg::PartiesDef - 1;  // revealed slots stored per gate
  localparam int CarrySteps   = mgv_pkg::WordBits - 1;
  localparam int SettleCycles = 60;              // > ADD gate carry walk plus read-back
  localparam int QuietLimit   = 2000;            // cycles with no transaction at all
  localparam int MaxIdle      = 19;

  typedef enum int {FillRandom, FillZero, FillOnes} fill_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own slot store and gate counter, predicts the
  // per-slot results when a gate closes and checks them in order.
  // --------------------------------------------------------------------------
  class gate_result_board_t;
    logic [mgv_pkg::CfgBits-1:0]  hidden_party;
    mgv_pkg::word_t               x_share[NumSlots];
    mgv_pkg::word_t               y_share[NumSlots];
    mgv_pkg::word_t               lambda[NumSlots];
    mgv_pkg::word_t               product[NumSlots];
    int                           stored;
    logic [mgv_pkg::GateBits-1:0] gate_count;
    mgv_pkg::result_t             expected_results[$];
    int                           errors;

    function new();
      hidden_party = '0;
      stored       = 0;
      gate_count   = '0;
      errors       = 0;
    endfunction

    // bit i+1 = XOR of bits 0..i, bit 0 = 0
    function mgv_pkg::word_t shifted_prefix_parity(mgv_pkg::word_t w);
      mgv_pkg::word_t r;
      logic           acc;
      r   = '0;
      acc = 1'b0;
      for (int i = 0; i < mgv_pkg::WordBits - 1; i++) begin
        acc      = acc ^ w[i];
        r[i + 1] = acc;
      end
      return r;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void note_item(mgv_pkg::item_t it);
      mgv_pkg::word_t   sx, sy, sp, sl, carry, zpub, ph, qh, cm, s;
      mgv_pkg::word_t   bcast[NumSlots];
      mgv_pkg::word_t   omask[NumSlots];
      logic             p0_revealed, pb, qb, sr;
      int               n;
      mgv_pkg::result_t r;
      // slot data beyond the store depth is dropped
      if (stored < NumSlots) begin
        x_share[stored] = it.x_mask;
        y_share[stored] = it.y_mask;
        lambda[stored]  = it.mask_rand;
        product[stored] = it.prod_rand;
        stored++;
      end
      if (!it.last_slot) return;

      p0_revealed = (hidden_party != '0);
      n     = stored;
      sx    = '0;
      sy    = '0;
      sp    = '0;
      sl    = '0;
      carry = '0;
      if (it.func) begin
        for (int j = 0; j < n; j++) begin
          cm = shifted_prefix_parity(lambda[j]);
          sx ^= x_share[j] ^ cm;
          sy ^= y_share[j] ^ cm;
          sp ^= product[j];
          sl ^= lambda[j];
        end
        // rebuild the public carry word one bit at a time
        for (int b = 0; b < CarrySteps; b++) begin
          pb = it.x_pub[b] ^ carry[b];
          qb = it.y_pub[b] ^ carry[b];
          sr = (pb & sy[b]) ^ (qb & sx[b]) ^ sp[b] ^ sl[b]
             ^ (p0_revealed & ((pb & qb) ^ it.correction[b]));
          carry[b + 1] = carry[b] ^ it.hidden_msg[b] ^ sr;
        end
        zpub = it.x_pub ^ it.y_pub ^ carry;
      end else begin
        zpub = it.hidden_msg;
      end

      // carry is zero for AND, so ph/qh are the plain public operands there
      ph = it.x_pub ^ carry;
      qh = it.y_pub ^ carry;
      for (int j = 0; j < n; j++) begin
        cm = it.func ? shifted_prefix_parity(lambda[j]) : '0;
        s  = (ph & (y_share[j] ^ cm)) ^ (qh & (x_share[j] ^ cm)) ^ product[j] ^ lambda[j];
        if (j == 0 && p0_revealed) s ^= (ph & qh) ^ it.correction;
        if (!it.func) zpub ^= s;
        bcast[j] = s;
        omask[j] = it.func ? (x_share[j] ^ y_share[j] ^ cm) : lambda[j];
      end

      for (int j = 0; j < n; j++) begin
        r.slot_broadcast = bcast[j];
        r.out_mask       = omask[j];
        r.out_pub        = zpub;
        r.gate_index     = gate_count;
        r.slot_index     = j[0];
        r.last_result    = (j == n - 1);
        expected_results.push_back(r);
      end
      stored     = 0;
      gate_count = gate_count + 1'b1;
    endfunction

    function void compare_field(string name, logic [mgv_pkg::WordBits-1:0] want,
                                logic [mgv_pkg::WordBits-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(mgv_pkg::result_t got);
      mgv_pkg::result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("slot_broadcast", want.slot_broadcast, got.slot_broadcast);
      compare_field("out_mask", want.out_mask, got.out_mask);
      compare_field("out_pub", want.out_pub, got.out_pub);
      compare_field("gate_index", 32'(want.gate_index), 32'(got.gate_index));
      compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
      compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        cfg_wr_en    = 1'b0;
  logic [mgv_pkg::CfgBits-1:0] cfg_wr_data  = '0;
  logic                        item_valid   = 1'b0;
  logic                        item_stall;
  mgv_pkg::item_t              item         = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  mgv_pkg::result_t            result;

  gate_result_board_t board = new();
  bit                 send_burst = 1'b0;  // sender runs back to back when set
  bit                 recv_burst = 1'b0;  // receiver never stalls when set
  int                 items_sent = 0;     // transactions whose content matters
  int                 quiet_cycles = 0;

  masked_gate_verify_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  // Watchdog: a hang shows up as a long run of cycles with no transaction.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic mgv_pkg::word_t pick_word(fill_t f);
    case (f)
      FillZero: return '0;
      FillOnes: return '1;
      default: begin
        case ($urandom_range(0, 9))
          0:       return '0;
          1:       return '1;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // Optional idle gap, then present the transaction and hold it until taken.
  // A zero gap keeps valid high straight into the next transaction.
  task automatic send_item(input mgv_pkg::item_t it);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(it);
  endtask

  // One gate: slots-1 plain slot transactions, then the closing one.
  // Random fill also scrambles func on the non-closing transactions,
  // which the block must not look at.
  task automatic run_gate(input logic fn, input int slots, input fill_t f);
    mgv_pkg::item_t it;
    for (int k = 0; k < slots; k++) begin
      it.func       = (k == slots - 1 || f != FillRandom) ? fn : logic'($urandom_range(0, 1));
      it.x_pub      = pick_word(f);
      it.y_pub      = pick_word(f);
      it.x_mask     = pick_word(f);
      it.y_mask     = pick_word(f);
      it.mask_rand  = pick_word(f);
      it.prod_rand  = pick_word(f);
      it.hidden_msg = pick_word(f);
      it.correction = pick_word(f);
      it.last_slot  = (k == slots - 1);
      send_item(it);
      if (k < NumSlots || it.last_slot) items_sent++;
    end
  endtask

  // Drop valid and hold off until every predicted result is back.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Register write only with the block idle; the settle time covers a
  // gate still in its carry walk when the last result came out.
  task automatic write_hidden(input logic [mgv_pkg::CfgBits-1:0] value);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.hidden_party = value;
  endtask

  // Mostly full gates with random words; some short and some overlong.
  // Somewhere in the middle the sender waits for the result queue to empty.
  task automatic random_phase(input logic [mgv_pkg::CfgBits-1:0] hp, input int quota);
    int start_count, pause_at, slots, pick;
    write_hidden(hp);
    start_count = items_sent;
    pause_at    = $urandom_range(quota / 4, 3 * quota / 4);
    while (items_sent - start_count < quota) begin
      if (pause_at >= 0 && items_sent - start_count >= pause_at) begin
        drain_results();
        pause_at = -1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) slots = NumSlots;
      else if (pick < 17) slots = 1;
      else slots = $urandom_range(NumSlots + 1, NumSlots + 2);
      if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
      run_gate(logic'($urandom_range(0, 1)), slots, FillRandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per transaction, burst stretches with none
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, MaxIdle);
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      board.check_result(result);
      if ($urandom_range(0, 24) == 0) recv_burst = !recv_burst;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, both gate kinds, short gates, overlong gates
    write_hidden(2'd0);
    run_gate(1'b0, NumSlots, FillZero);
    run_gate(1'b1, NumSlots, FillOnes);
    run_gate(1'b0, NumSlots, FillOnes);
    run_gate(1'b1, NumSlots, FillZero);
    run_gate(1'b0, 1, FillRandom);             // short gate, AND
    run_gate(1'b1, 1, FillRandom);             // short gate, ADD
    run_gate(1'b1, NumSlots + 2, FillRandom);  // extra slots dropped, ADD
    run_gate(1'b0, NumSlots + 1, FillRandom);  // extra slots dropped, AND

    // random phases; 3 is out of the nominal range and acts like 1 and 2
    random_phase(2'd2, 75);
    random_phase(2'd1, 75);
    random_phase(2'd3, 75);
    random_phase(2'd0, 70);

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
